/* sv/wifi_data_to_ethernet_decapsulator_defines.svh */
// ----------------------------------------------------------------------------
// wifi data to ethernet decapsulator assertion macros
// shared property wrappers for the block's checkers
// ----------------------------------------------------------------------------
`ifndef WIFI_DATA_TO_ETHERNET_DECAPSULATOR_DEFINES_SVH
`define WIFI_DATA_TO_ETHERNET_DECAPSULATOR_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define WDEC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wdec assertion failed");

// next-cycle implication, clocked on clk_i, off during reset
`define WDEC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wdec assertion failed");

`endif

/* sv/wdec_pkg.sv */
// ----------------------------------------------------------------------------
// wdec package
// shared constants and types of the 802.11 to ethernet decapsulator
// ----------------------------------------------------------------------------
package wdec_pkg;

  localparam int unsigned MaxFrameBytes = 4096;
  localparam int unsigned IdxW          = $clog2(MaxFrameBytes + 1);
  localparam int unsigned LenW          = 12;
  localparam int unsigned EthHdrBytes   = 14;
  localparam int unsigned BurstW        = $clog2(EthHdrBytes + 1);
  localparam int unsigned AddrW         = 48;

  localparam int unsigned HdrLen        = 24;
  localparam int unsigned QosHdrLen     = 26;
  localparam int unsigned MinFrameLen   = 32;

  localparam logic [15:0] FcTypeMask    = 16'h000c;
  localparam logic [15:0] FcTypeData    = 16'h0008;
  localparam logic [15:0] FcQos         = 16'h0080;
  localparam logic [15:0] FcToDs        = 16'h0100;
  localparam logic [15:0] FcFromDs      = 16'h0200;
  localparam logic [15:0] FcDsMask      = 16'h0300;
  localparam logic [7:0]  LlcSap        = 8'haa;
  localparam logic [7:0]  LlcCtrl       = 8'h03;

  localparam logic [LenW-1:0] MaxEthLenRst = LenW'(1514);

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StShort   = 2'd1,
    StUnsup   = 2'd2,
    StNoSpace = 2'd3
  } status_e;

  typedef struct packed {
    logic                             valid;
    logic [BurstW-1:0]                count;
    logic                             eof;
    status_e                          status;
    logic [EthHdrBytes-1:0][7:0]      bytes;
  } job_t;

endpackage

/* sv/wdec_parse.sv */
// ----------------------------------------------------------------------------
// wdec parse
// header capture, llc check and per-word result generation
// ----------------------------------------------------------------------------
module wdec_parse (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [wdec_pkg::LenW-1:0] cfg_wdata_i,
  input  logic                      fire_i,
  input  logic [7:0]                data_byte_i,
  input  logic                      last_byte_i,
  output wdec_pkg::job_t            job_o
);

  localparam int unsigned IdxW  = wdec_pkg::IdxW;
  localparam int unsigned LenW  = wdec_pkg::LenW;
  localparam int unsigned AddrW = wdec_pkg::AddrW;

  logic [LenW-1:0]  max_q;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [15:0]      fc_q, fc_d;
  logic [AddrW-1:0] ra_q, ra_d, ta_q, ta_d, a3_q, a3_d;
  logic [7:0]       et_hi_q, et_hi_d;
  wdec_pkg::status_e err_q, err_d;
  logic [LenW-1:0]  emitted_q, emitted_d;

  logic [IdxW-1:0]  i;
  logic [IdxW-1:0]  hdr;
  logic [IdxW-1:0]  rel;
  logic [7:0]       want;
  logic [AddrW-1:0] da, sa;
  wdec_pkg::status_e st;
  wdec_pkg::job_t   job;

  function automatic logic fc_unsupported(input logic [15:0] fc);
    return ((fc & wdec_pkg::FcTypeMask) != wdec_pkg::FcTypeData) ||
           ((fc & wdec_pkg::FcDsMask) == wdec_pkg::FcDsMask);
  endfunction

  always_comb begin
    i         = idx_q;
    fc_d      = fc_q;
    ra_d      = ra_q;
    ta_d      = ta_q;
    a3_d      = a3_q;
    et_hi_d   = et_hi_q;
    err_d     = err_q;
    emitted_d = emitted_q;
    job       = '0;
    rel       = '0;
    want      = wdec_pkg::LlcSap;
    st        = wdec_pkg::StOk;

    // header field capture
    if (i == IdxW'(0)) begin
      fc_d[7:0] = data_byte_i;
    end else if (i == IdxW'(1)) begin
      fc_d[15:8] = data_byte_i;
    end else if (i >= IdxW'(4) && i < IdxW'(10)) begin
      ra_d = {ra_q[AddrW-9:0], data_byte_i};
    end else if (i >= IdxW'(10) && i < IdxW'(16)) begin
      ta_d = {ta_q[AddrW-9:0], data_byte_i};
    end else if (i >= IdxW'(16) && i < IdxW'(22)) begin
      a3_d = {a3_q[AddrW-9:0], data_byte_i};
    end

    hdr = ((fc_d & wdec_pkg::FcQos) != '0) ? IdxW'(wdec_pkg::QosHdrLen)
                                            : IdxW'(wdec_pkg::HdrLen);

    if (i == IdxW'(1) && fc_unsupported(fc_d)) begin
      err_d = wdec_pkg::StUnsup;
    end

    // address selection by to-ds / from-ds
    if ((fc_d & wdec_pkg::FcToDs) != '0) begin
      da = a3_q;
      sa = ta_q;
    end else if ((fc_d & wdec_pkg::FcFromDs) != '0) begin
      da = ra_q;
      sa = a3_q;
    end else begin
      da = ra_q;
      sa = ta_q;
    end

    if (err_d != wdec_pkg::StUnsup && i >= hdr) begin
      if (i < hdr + IdxW'(3)) begin
        rel  = i - hdr;
        want = (rel < IdxW'(2)) ? wdec_pkg::LlcSap : wdec_pkg::LlcCtrl;
        if (data_byte_i != want) begin
          err_d = wdec_pkg::StUnsup;
        end
      end else if (i == hdr + IdxW'(6)) begin
        et_hi_d = data_byte_i;
      end else if (i == hdr + IdxW'(7)) begin
        for (int k = 0; k < 6; k++) begin
          job.bytes[k]     = da[8*(5-k) +: 8];
          job.bytes[6 + k] = sa[8*(5-k) +: 8];
        end
        job.bytes[12] = et_hi_q;
        job.bytes[13] = data_byte_i;
        if (max_q < LenW'(wdec_pkg::EthHdrBytes)) begin
          job.count = max_q[wdec_pkg::BurstW-1:0];
          err_d     = wdec_pkg::StNoSpace;
        end else begin
          job.count = wdec_pkg::BurstW'(wdec_pkg::EthHdrBytes);
        end
        emitted_d = LenW'(job.count);
        job.valid = (job.count != '0);
      end else if (i > hdr + IdxW'(7)) begin
        if (emitted_q < max_q) begin
          job.valid    = 1'b1;
          job.count    = wdec_pkg::BurstW'(1);
          job.bytes[0] = data_byte_i;
          emitted_d    = emitted_q + LenW'(1);
        end else begin
          err_d = wdec_pkg::StNoSpace;
        end
      end
    end

    idx_d = (i < IdxW'(wdec_pkg::MaxFrameBytes)) ? i + IdxW'(1) : i;

    if (last_byte_i) begin
      if (i < IdxW'(wdec_pkg::MinFrameLen - 1)) begin
        st = wdec_pkg::StShort;
      end else if (fc_unsupported(fc_d)) begin
        st = wdec_pkg::StUnsup;
      end else if (i < hdr + IdxW'(7)) begin
        st = wdec_pkg::StShort;
      end else begin
        st = err_d;
      end

      if (st == wdec_pkg::StShort || st == wdec_pkg::StUnsup || !job.valid) begin
        job       = '0;
        job.valid = 1'b1;
        job.count = wdec_pkg::BurstW'(1);
      end
      job.eof    = 1'b1;
      job.status = st;

      idx_d     = '0;
      fc_d      = '0;
      ra_d      = '0;
      ta_d      = '0;
      a3_d      = '0;
      et_hi_d   = '0;
      err_d     = wdec_pkg::StOk;
      emitted_d = '0;
    end
  end

  always_comb begin
    job_o       = job;
    job_o.valid = job.valid && fire_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q     <= wdec_pkg::MaxEthLenRst;
      idx_q     <= '0;
      fc_q      <= '0;
      ra_q      <= '0;
      ta_q      <= '0;
      a3_q      <= '0;
      et_hi_q   <= '0;
      err_q     <= wdec_pkg::StOk;
      emitted_q <= '0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (fire_i) begin
        idx_q     <= idx_d;
        fc_q      <= fc_d;
        ra_q      <= ra_d;
        ta_q      <= ta_d;
        a3_q      <= a3_d;
        et_hi_q   <= et_hi_d;
        err_q     <= err_d;
        emitted_q <= emitted_d;
      end
    end
  end

endmodule

/* sv/wdec_emit.sv */
// ----------------------------------------------------------------------------
// wdec emit
// result buffer and output register, drains header bursts one word a cycle while the output is not stalled
// ----------------------------------------------------------------------------
module wdec_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wdec_pkg::job_t    job_i,
  output logic              job_ready_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [7:0]        eth_byte_o,
  output logic              end_of_frame_o,
  output wdec_pkg::status_e status_o
);

  localparam int unsigned BurstW = wdec_pkg::BurstW;
  localparam int unsigned NBytes = wdec_pkg::EthHdrBytes;

  logic [NBytes-1:0][7:0] buf_q, buf_d;
  logic [BurstW-1:0]      rem_q, rem_d;
  logic                   eof_q, eof_d;
  wdec_pkg::status_e      st_q, st_d;
  logic                   ov_q, ov_d;
  logic [7:0]             ob_q, ob_d;
  logic                   oe_q, oe_d;
  wdec_pkg::status_e      os_q, os_d;

  logic slot_free;
  logic rem_one;

  assign slot_free   = !ov_q || !out_stall_i;
  assign rem_one     = (rem_q == BurstW'(1));
  assign job_ready_o = (rem_q == '0) || (rem_one && slot_free);

  always_comb begin
    buf_d = buf_q;
    rem_d = rem_q;
    eof_d = eof_q;
    st_d  = st_q;
    ov_d  = ov_q;
    ob_d  = ob_q;
    oe_d  = oe_q;
    os_d  = os_q;

    if (slot_free) begin
      ov_d = 1'b0;
      if (rem_q != '0) begin
        ov_d  = 1'b1;
        ob_d  = buf_q[0];
        oe_d  = eof_q && rem_one;
        os_d  = rem_one ? st_q : wdec_pkg::StOk;
        buf_d = {8'h00, buf_q[NBytes-1:1]};
        rem_d = rem_q - BurstW'(1);
      end
    end

    if (job_i.valid) begin
      buf_d = job_i.bytes;
      rem_d = job_i.count;
      eof_d = job_i.eof;
      st_d  = job_i.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      rem_q <= rem_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    eof_q <= eof_d;
    st_q  <= st_d;
    ob_q  <= ob_d;
    oe_q  <= oe_d;
    os_q  <= os_d;
  end

  assign out_valid_o    = ov_q;
  assign eth_byte_o     = ob_q;
  assign end_of_frame_o = oe_q;
  assign status_o       = os_q;

endmodule

/* sv/wifi_data_to_ethernet_decapsulator.sv */
// ----------------------------------------------------------------------------
// wifi data to ethernet decapsulator
// turns a byte stream of 802.11 data frames into ethernet frames (llc/snap)
// ----------------------------------------------------------------------------
// Takes one word per cycle while in_stall_o is low. A payload word goes into
// the result buffer at the edge that accepts it and from there into the output
// register, from which it is offered. When the ethertype completes, the
// 14-word ethernet header goes into the same buffer and drains one word a cycle
// while the output is not stalled, so the input stalls once per frame while it
// drains; apart from that the rate is one word per cycle. Short or unsupported
// frames give a single zero word with end_of_frame and the status set.
module wifi_data_to_ethernet_decapsulator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [wdec_pkg::LenW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                data_byte_i,
  input  logic                      last_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [7:0]                eth_byte_o,
  output logic                      end_of_frame_o,
  output logic [1:0]                status_o
);

  wdec_pkg::job_t    job;
  logic              job_ready;
  logic              fire;
  wdec_pkg::status_e status;

  assign in_stall_o = !job_ready;
  assign fire       = in_valid_i && job_ready;

  wdec_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .job_o       (job)
  );

  wdec_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_i          (job),
    .job_ready_o    (job_ready),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .eth_byte_o     (eth_byte_o),
    .end_of_frame_o (end_of_frame_o),
    .status_o       (status)
  );

  assign status_o = status;

endmodule

/* sv/wdec_checker.sv */
// ----------------------------------------------------------------------------
// wdec checker
// port-level properties of the decapsulator, bound to the top level
// ----------------------------------------------------------------------------
`include "wifi_data_to_ethernet_decapsulator_defines.svh"

module wdec_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      cfg_we_i,
  input logic [wdec_pkg::LenW-1:0] cfg_wdata_i,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic [7:0]                data_byte_i,
  input logic                      last_byte_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [7:0]                eth_byte_o,
  input logic                      end_of_frame_o,
  input logic [1:0]                status_o
);

  // stalled result word holds
  `WDEC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                    out_valid_o && $stable(eth_byte_o) && $stable(end_of_frame_o) &&
                    $stable(status_o))

  // status only on the closing word
  `WDEC_ASSERT_IMP(a_status_at_eof, out_valid_o && !end_of_frame_o, status_o == wdec_pkg::StOk)

  // short or unsupported frames give one zero closing word
  `WDEC_ASSERT_IMP(a_err_word,
                   out_valid_o && (status_o == wdec_pkg::StShort ||
                                   status_o == wdec_pkg::StUnsup),
                   eth_byte_o == 8'h00 && end_of_frame_o)

endmodule

bind wifi_data_to_ethernet_decapsulator wdec_checker u_wdec_checker (.*);

/* test/wifi_data_to_ethernet_decapsulator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wifi data to ethernet decapsulator testbench
// feeds 802.11 frames one word at a time and checks every ethernet word that
// comes out against a predictor of the decapsulation; a short table of
// directed frames comes first, then random frames in three phases of idling
// ----------------------------------------------------------------------------
module wifi_data_to_ethernet_decapsulator_tb;
  import wdec_pkg::*;

  localparam int HoldCycles    = 300;
  localparam int SettleCycles  = 32;
  localparam int WatchdogLimit = 2000;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
    status_e    st;
  } eth_word_t;

  typedef struct packed {
    logic      given;
    eth_word_t word;
  } frame_check_t;

  typedef struct {
    logic [LenW-1:0] mtu;
    logic [15:0]     fc;
    int              pay;
    int              cut;
    int              bad;
    int              fill;
    logic            given;
    status_e         st;
  } frame_row_t;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            cfg_we_i    = 1'b0;
  logic [LenW-1:0] cfg_wdata_i = '0;
  logic            in_valid_i  = 1'b0;
  logic            in_stall_o;
  logic [7:0]      data_byte_i = '0;
  logic            last_byte_i = 1'b0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic [7:0]      eth_byte_o;
  logic            end_of_frame_o;
  logic [1:0]      status_o;

  // predictor state
  logic [LenW-1:0] eth_limit = MaxEthLenRst;
  int unsigned     rx_count  = 0;
  logic [15:0]     rx_fc     = '0;
  logic [47:0]     rx_addr1  = '0;
  logic [47:0]     rx_addr2  = '0;
  logic [47:0]     rx_addr3  = '0;
  logic [15:0]     rx_type   = '0;
  status_e         rx_err    = StOk;
  int unsigned     tx_count  = 0;

  eth_word_t    step_words[$];
  eth_word_t    pending_eth_words[$];
  frame_check_t frame_checks[$];
  logic [7:0]   frame_bytes[$];

  int mismatches   = 0;
  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  int holds_asked  = 0;
  int holds_done   = 0;

  wifi_data_to_ethernet_decapsulator u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .eth_byte_o     (eth_byte_o),
    .end_of_frame_o (end_of_frame_o),
    .status_o       (status_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic fc_unsupported(input logic [15:0] fc);
    return ((fc & FcTypeMask) != FcTypeData) || ((fc & FcDsMask) == FcDsMask);
  endfunction

  task automatic put_eth(input logic [7:0] b);
    if (tx_count < eth_limit) begin
      step_words.push_back({b, 1'b0, StOk});
      tx_count++;
    end else begin
      rx_err = StNoSpace;
    end
  endtask

  task automatic decapsulate_byte(input logic [7:0] b, input logic last);
    int unsigned i;
    int unsigned hdr;
    int unsigned len;
    int unsigned k;
    logic [47:0] da;
    logic [47:0] sa;
    status_e     st;
    eth_word_t   w;
    step_words.delete();
    i = rx_count;
    if (i < 2) begin
      rx_fc[8*i +: 8] = b;
      if (i == 1 && fc_unsupported(rx_fc)) rx_err = StUnsup;
    end else if (i >= 4 && i < 10) begin
      rx_addr1 = {rx_addr1[39:0], b};
    end else if (i >= 10 && i < 16) begin
      rx_addr2 = {rx_addr2[39:0], b};
    end else if (i >= 16 && i < 22) begin
      rx_addr3 = {rx_addr3[39:0], b};
    end
    hdr = ((rx_fc & FcQos) != 0) ? QosHdrLen : HdrLen;
    if (rx_err != StUnsup && i >= hdr) begin
      if (i < hdr + 3) begin
        if (b != ((i - hdr < 2) ? LlcSap : LlcCtrl)) rx_err = StUnsup;
      end else if (i == hdr + 6) begin
        rx_type = {b, 8'h00};
      end else if (i == hdr + 7) begin
        rx_type[7:0] = b;
        if ((rx_fc & FcToDs) != 0) begin
          da = rx_addr3;
          sa = rx_addr2;
        end else if ((rx_fc & FcFromDs) != 0) begin
          da = rx_addr1;
          sa = rx_addr3;
        end else begin
          da = rx_addr1;
          sa = rx_addr2;
        end
        for (k = 0; k < 6; k++) put_eth(da[47 - 8*k -: 8]);
        for (k = 0; k < 6; k++) put_eth(sa[47 - 8*k -: 8]);
        put_eth(rx_type[15:8]);
        put_eth(rx_type[7:0]);
      end else if (i > hdr + 7) begin
        put_eth(b);
      end
    end
    if (rx_count < MaxFrameBytes) rx_count++;
    if (last) begin
      len = i + 1;
      if (len < MinFrameLen) st = StShort;
      else if (fc_unsupported(rx_fc)) st = StUnsup;
      else if (len < hdr + 8) st = StShort;
      else if (rx_err == StUnsup) st = StUnsup;
      else st = rx_err;
      if (st == StShort || st == StUnsup || step_words.size() == 0) begin
        step_words.delete();
        step_words.push_back({8'h00, 1'b1, st});
      end else begin
        w = step_words.pop_back();
        w.eof = 1'b1;
        w.st  = st;
        step_words.push_back(w);
      end
      rx_count = 0;
      rx_fc    = '0;
      rx_addr1 = '0;
      rx_addr2 = '0;
      rx_addr3 = '0;
      rx_type  = '0;
      rx_err   = StOk;
      tx_count = 0;
    end
  endtask

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk_i) begin : take_in
    frame_check_t chk;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      decapsulate_byte(data_byte_i, last_byte_i);
      if (last_byte_i && frame_checks.size() != 0) begin
        chk = frame_checks.pop_front();
        if (chk.given) begin
          step_words.delete();
          step_words.push_back(chk.word);
        end
      end
      foreach (step_words[n]) pending_eth_words.push_back(step_words[n]);
    end
  end

  always @(posedge clk_i) begin : take_out
    eth_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_eth_words.size() == 0) begin
        flag_mismatch($sformatf("unexpected word %02h eof %0d status %0d",
                                eth_byte_o, end_of_frame_o, status_o));
      end else begin
        want = pending_eth_words.pop_front();
        if (eth_byte_o !== want.data || end_of_frame_o !== want.eof ||
            status_o !== want.st) begin
          flag_mismatch($sformatf("expected %02h/%0d/%0d got %02h/%0d/%0d",
                                  want.data, want.eof, want.st,
                                  eth_byte_o, end_of_frame_o, status_o));
        end
      end
    end
  end

  // receiver: random stalls, or one long hold-off when asked
  initial begin : receiver
    int n;
    forever begin
      @(posedge clk_i);
      if (holds_asked != holds_done) begin
        holds_done++;
        out_stall_i <= 1'b1;
        for (n = 0; n < HoldCycles; n++) @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_gap_pct);
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < WatchdogLimit) begin
      @(posedge clk_i);
      if ((rst_ni && in_valid_i && !in_stall_o) || (rst_ni && out_valid_o && !out_stall_i))
        stuck = 0;
      else
        stuck++;
    end
    $display("status: fail");
    $finish;
  end

  task automatic send_word(input logic [7:0] b, input logic last);
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_gap_pct) @(posedge clk_i);
    end
  endtask

  task automatic build_frame(input logic [15:0] fc, input int pay, input int cut,
                             input int bad, input int fill);
    int         hdr;
    int         total;
    int         n;
    logic [7:0] b;
    frame_bytes.delete();
    hdr   = ((fc & FcQos) != 0) ? QosHdrLen : HdrLen;
    total = hdr + 8 + pay;
    for (n = 0; n < total; n++) begin
      case (fill)
        1: b = 8'h00;
        2: b = 8'hff;
        default: b = 8'($urandom);
      endcase
      if (n == 0) b = fc[7:0];
      else if (n == 1) b = fc[15:8];
      else if (n >= hdr && n < hdr + 3) b = (n - hdr < 2) ? LlcSap : LlcCtrl;
      if (bad >= 0 && n == hdr + bad) b = b ^ (8'd1 << $urandom_range(7));
      frame_bytes.push_back(b);
    end
    if (cut > 0) begin
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    end
  endtask

  task automatic send_frame(input logic given, input status_e st);
    frame_check_t chk;
    int           n;
    chk.given = given;
    chk.word  = {8'h00, 1'b1, st};
    frame_checks.push_back(chk);
    for (n = 0; n < frame_bytes.size(); n++)
      send_word(frame_bytes[n], n == frame_bytes.size() - 1);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_eth_words.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [LenW-1:0] v);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    eth_limit = v;
  endtask

  task automatic run_random_phase(input int send_pct, input int recv_pct,
                                  input logic [LenW-1:0] lim, input int frames,
                                  input logic squeeze);
    int          f;
    int          kind;
    int          pay;
    int          cut;
    int          bad;
    logic [15:0] fc;
    set_limit(lim);
    send_gap_pct = send_pct;
    recv_gap_pct = recv_pct;
    if (squeeze) holds_asked++;
    for (f = 0; f < frames; f++) begin
      kind = $urandom_range(99);
      fc   = 16'($urandom);
      pay  = int'($urandom_range(4));
      cut  = 0;
      bad  = -1;
      if (kind < 80) begin
        fc = (fc & ~FcTypeMask) | FcTypeData;
        if ((fc & FcDsMask) == FcDsMask) fc[$urandom_range(9, 8)] = 1'b0;
        // broken llc or truncated frame
        if (kind >= 70) begin
          if ($urandom_range(1)) bad = $urandom_range(2);
          else cut = $urandom_range(40, 1);
        end
      end else if (kind < 90) begin
        if ($urandom_range(1)) fc = fc | FcDsMask;
        else if (fc[3:2] == 2'b10) fc[3:2] = 2'b11;
      end else begin
        if ($urandom_range(1)) cut = $urandom_range(48, 1);
        if ($urandom_range(1)) bad = $urandom_range(2);
      end
      build_frame(fc, pay, cut, bad, 0);
      send_frame(1'b0, StOk);
    end
  endtask

  initial begin : main
    frame_row_t rows[$];
    frame_row_t r;
    // mtu, fc, payload, cut length, bad llc byte, fill, typed, status
    rows.push_back('{1514, 16'h0188, 0,    0,  -1, 0, 1'b0, StOk});
    rows.push_back('{1514, 16'h0308, 0,    0,  -1, 0, 1'b1, StUnsup});
    rows.push_back('{1514, 16'h0008, 4,    20, -1, 0, 1'b1, StShort});
    rows.push_back('{1514, 16'h0008, 0,    0,  0,  0, 1'b1, StUnsup});
    rows.push_back('{14,   16'h0008, 1,    0,  -1, 0, 1'b1, StNoSpace});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[n]) begin
      r = rows[n];
      if (r.mtu != eth_limit) set_limit(r.mtu);
      build_frame(r.fc, r.pay, r.cut, r.bad, r.fill);
      send_frame(r.given, r.st);
    end

    run_random_phase(34, 50, 12'd4095, 1, 1'b1);
    run_random_phase(50, 34, 12'($urandom_range(80, 14)), 1, 1'b0);
    run_random_phase(0, 0, MaxEthLenRst, 1, 1'b0);
    settle();

    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/wdec_pkg.sv
sv/wdec_parse.sv
sv/wdec_emit.sv
sv/wifi_data_to_ethernet_decapsulator.sv
sv/wdec_checker.sv
test/wifi_data_to_ethernet_decapsulator_tb.sv
